// ----- rtl/tpd_pkg.sv -----
// Shared widths, constants and the remainder step for the track point decimator.
`timescale 1ns / 1ps
`default_nettype none

package tpd_pkg;

	localparam int TS_W        = 40;
	localparam int HDG_W       = 16;
	localparam int INDEX_WIDTH = 20;
	localparam int OFS_W       = 20;
	localparam int MODE_W      = 2;
	localparam int TSTEP_W     = 17;
	localparam int THR_W       = 16;
	localparam int PSTEP_W     = 16;
	localparam int MAXP_W      = 20;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 20;
	localparam int S_TDATA_W   = ((TS_W + HDG_W + 7) / 8) * 8;
	localparam int S_TUSER_W   = 2;
	localparam int M_TDATA_W   = ((OFS_W + 7) / 8) * 8;

	localparam logic [TSTEP_W-1:0] DAY_SECS  = TSTEP_W'(86400);
	localparam logic [HDG_W-1:0]   FULL_TURN = HDG_W'(36000);
	localparam logic [HDG_W-1:0]   HALF_TURN = HDG_W'(18000);

	localparam int DAY_STEPS  = TS_W / 2;
	localparam int SOD_STEPS  = (TSTEP_W + 1) / 2;
	localparam int SOD_PAD    = 2 * SOD_STEPS;
	localparam int STEP_CNT_W = $clog2(DAY_STEPS);

	// one restoring-division step: shift in a bit, subtract the divisor if it fits
	function automatic logic [TSTEP_W-1:0] mod_bit(input logic [TSTEP_W-1:0] rem,
		input logic din, input logic [TSTEP_W-1:0] dvs);
		logic [TSTEP_W:0] trial;
		trial = {rem, din};
		if (trial >= {1'b0, dvs}) begin
			return TSTEP_W'(trial - {1'b0, dvs});
		end
		return trial[TSTEP_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/tpd_grid_unit.sv -----
// Digit-serial grid time unit: time of day, remainder by the step, next grid time.
`timescale 1ns / 1ps
`default_nettype none

module tpd_grid_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tpd_pkg::TS_W-1:0]    ts,
	input  logic [tpd_pkg::TSTEP_W-1:0] step,
	output logic                        done,
	output logic [tpd_pkg::TS_W-1:0]    next_time
);
	import tpd_pkg::*;

	typedef enum logic [1:0] {U_IDLE, U_DAY, U_SOD, U_ADD} ustate_t;

	ustate_t              state_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [TS_W-1:0]      nxt_q;
	logic [TS_W-1:0]      ts_q;
	logic [TS_W-1:0]      sh_q;
	logic [TSTEP_W-1:0]   step_q;
	logic [TSTEP_W-1:0]   rem_q;
	logic [TSTEP_W-1:0]   inc_q;
	logic [TSTEP_W-1:0]   dvs;
	logic [TSTEP_W-1:0]   rem_mid;
	logic [TSTEP_W-1:0]   rem_nx;
	logic [TS_W:0]        sum;
	logic                 day_last;
	logic                 sod_last;

	always_comb begin
		dvs      = (state_q == U_DAY) ? DAY_SECS : step_q;
		rem_mid  = mod_bit(rem_q, sh_q[TS_W-1], dvs);
		rem_nx   = mod_bit(rem_mid, sh_q[TS_W-2], dvs);
		sum      = {1'b0, ts_q} + (TS_W + 1)'(inc_q);
		day_last = (cnt_q == STEP_CNT_W'(DAY_STEPS - 1));
		sod_last = (cnt_q == STEP_CNT_W'(SOD_STEPS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			nxt_q   <= '0;
		end else begin
			done_q <= (state_q == U_ADD);
			unique case (state_q)
				U_IDLE: begin
					if (start) begin
						state_q <= U_DAY;
						cnt_q   <= '0;
					end
				end
				U_DAY: begin
					if (day_last) begin
						state_q <= U_SOD;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				U_SOD: begin
					cnt_q <= cnt_q + 1'b1;
					if (sod_last) begin
						state_q <= U_ADD;
					end
				end
				U_ADD: begin
					nxt_q   <= sum[TS_W] ? '1 : sum[TS_W-1:0];
					state_q <= U_IDLE;
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			U_IDLE: begin
				if (start) begin
					ts_q   <= ts;
					step_q <= step;
					sh_q   <= ts;
					rem_q  <= '0;
				end
			end
			U_DAY: begin
				if (day_last) begin
					sh_q  <= TS_W'(rem_nx) << (TS_W - SOD_PAD);
					rem_q <= '0;
				end else begin
					rem_q <= rem_nx;
					sh_q  <= sh_q << 2;
				end
			end
			U_SOD: begin
				rem_q <= rem_nx;
				sh_q  <= sh_q << 2;
				if (sod_last) begin
					inc_q <= step_q - rem_nx;
				end
			end
			default: begin
			end
		endcase
	end

	assign done      = done_q;
	assign next_time = nxt_q;

endmodule

`default_nettype wire

// ----- rtl/track_point_decimator_core.sv -----
// Top level of the track point decimator: sample capture, keep decision, result register.
//
//  channel  dir  handshake                       payload
//  s_axis   in   s_axis_tvalid / s_axis_tready   tdata: timestamp, heading; tuser; tlast
//  m_axis   out  m_axis_tvalid / m_axis_tready   tdata: point_offset; tuser: keep
//  cfg      in   cfg_valid / cfg_ready           cfg_index, cfg_data
//
// One item at a time: capture, decide, register the result.
// A kept point in time-step mode with a nonzero step also waits for the grid
// unit, which works the remainders two bits per cycle (20 + 9 steps, one add).
// A result waiting on m_axis does not block the next item from being taken.
// Reset clears all trackers and loads the register defaults; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module track_point_decimator_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// timestamp_seconds [39:0], heading [55:40]
	input  logic [tpd_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// heading_valid [0], first_in_window [1]
	input  logic [tpd_pkg::S_TUSER_W-1:0]  s_axis_tuser,
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// point_offset [19:0], zeros above
	output logic [tpd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	// keep [0]
	output logic [0:0]                     m_axis_tuser,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tpd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tpd_pkg::*;

	typedef enum logic [MODE_W-1:0] {MODE_ALL, MODE_TIME, MODE_HEADING, MODE_POINT} mode_t;
	typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_GRID, ST_SEND} state_t;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TSTEP  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_THRESH = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_PSTEP  = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_MAXP   = CFG_IDX_W'(4);
	localparam logic [INDEX_WIDTH-1:0] IDX_MAX  = '1;

	mode_t                mode_q;
	logic [TSTEP_W-1:0]   tstep_q;
	logic [THR_W-1:0]     thr_q;
	logic [PSTEP_W-1:0]   pstep_q;
	logic [MAXP_W-1:0]    maxp_q;

	state_t               state_q;
	logic [TS_W-1:0]      ngt_q;
	logic [HDG_W-1:0]     lkh_q;
	logic [INDEX_WIDTH-1:0] sofs_q;
	logic [MAXP_W-1:0]    kcnt_q;
	logic [PSTEP_W-1:0]   cdown_q;
	logic                 hseen_q;
	logic                 grid_start_q;
	logic                 res_keep_q;
	logic [OFS_W-1:0]     res_ofs_q;
	logic                 m_valid_q;
	logic                 m_keep_q;
	logic [OFS_W-1:0]     m_ofs_q;

	logic [TS_W-1:0]      ts_q;
	logic [HDG_W-1:0]     hdg_q;
	logic                 hv_q;
	logic                 first_q;
	logic                 last_q;

	logic [HDG_W-1:0]     s_hdg;
	logic [HDG_W-1:0]     hdg_red;
	logic [INDEX_WIDTH-1:0] pos_w;
	logic [INDEX_WIDTH-1:0] sofs_nx;
	logic [HDG_W-1:0]     hdg_diff;
	logic [HDG_W-1:0]     hdg_chg;
	logic                 hseen_nx;
	logic [MAXP_W-1:0]    kcnt_nx;
	logic [PSTEP_W-1:0]   cdown_nx;
	logic [HDG_W-1:0]     lkh_nx;
	logic [TS_W-1:0]      ngt_nx;
	logic                 keep_w;
	logic                 grid_go;
	logic                 grid_done;
	logic [TS_W-1:0]      grid_next;

	tpd_grid_unit u_grid (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (grid_start_q),
		.ts        (ts_q),
		.step      (tstep_q),
		.done      (grid_done),
		.next_time (grid_next)
	);

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = M_TDATA_W'(m_ofs_q);
	assign m_axis_tuser  = m_keep_q;

	assign s_hdg   = s_axis_tdata[TS_W +: HDG_W];
	assign hdg_red = (s_hdg >= FULL_TURN) ? s_hdg - FULL_TURN : s_hdg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_ALL;
			tstep_q <= '0;
			thr_q   <= '0;
			pstep_q <= PSTEP_W'(1);
			maxp_q  <= '1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE:   mode_q  <= mode_t'(cfg_data[MODE_W-1:0]);
				REG_TSTEP:  tstep_q <= cfg_data[TSTEP_W-1:0];
				REG_THRESH: thr_q   <= cfg_data[THR_W-1:0];
				REG_PSTEP:  pstep_q <= cfg_data[PSTEP_W-1:0];
				REG_MAXP:   maxp_q  <= cfg_data[MAXP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ts_q    <= s_axis_tdata[TS_W-1:0];
			hdg_q   <= hdg_red;
			hv_q    <= s_axis_tuser[0];
			first_q <= s_axis_tuser[1];
			last_q  <= s_axis_tlast;
		end
	end

	always_comb begin
		pos_w    = first_q ? '0 : sofs_q;
		sofs_nx  = (pos_w == IDX_MAX) ? pos_w : pos_w + 1'b1;
		hdg_diff = (hdg_q > lkh_q) ? hdg_q - lkh_q : lkh_q - hdg_q;
		hdg_chg  = (hdg_diff > HALF_TURN) ? FULL_TURN - hdg_diff : hdg_diff;
		hseen_nx = first_q ? 1'b0 : hseen_q;
		kcnt_nx  = first_q ? '0 : kcnt_q;
		cdown_nx = first_q ? '0 : cdown_q;
		lkh_nx   = lkh_q;
		ngt_nx   = ngt_q;
		keep_w   = 1'b0;
		grid_go  = 1'b0;
		unique case (mode_q)
			MODE_ALL: keep_w = 1'b1;
			MODE_TIME: begin
				keep_w = first_q || last_q || (tstep_q == '0) || (ts_q >= ngt_q);
				if (keep_w) begin
					if (tstep_q == '0) begin
						ngt_nx = ts_q;
					end else begin
						grid_go = 1'b1;
					end
				end
			end
			MODE_HEADING: begin
				if (hv_q && (!hseen_nx || last_q || (hdg_chg >= thr_q))) begin
					keep_w   = 1'b1;
					lkh_nx   = hdg_q;
					hseen_nx = 1'b1;
				end
			end
			MODE_POINT: begin
				if (cdown_nx == '0) begin
					if (kcnt_nx < maxp_q) begin
						keep_w  = 1'b1;
						kcnt_nx = kcnt_nx + 1'b1;
					end
					cdown_nx = (pstep_q == '0) ? '0 : pstep_q - 1'b1;
				end else begin
					cdown_nx = cdown_nx - 1'b1;
				end
			end
			default: keep_w = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ngt_q        <= '0;
			lkh_q        <= '0;
			sofs_q       <= '0;
			kcnt_q       <= '0;
			cdown_q      <= '0;
			hseen_q      <= 1'b0;
			grid_start_q <= 1'b0;
			res_keep_q   <= 1'b0;
			res_ofs_q    <= '0;
			m_valid_q    <= 1'b0;
			m_keep_q     <= 1'b0;
			m_ofs_q      <= '0;
		end else begin
			grid_start_q <= (state_q == ST_EVAL) && grid_go;
			if (m_valid_q && m_axis_tready && (state_q != ST_SEND)) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					sofs_q     <= sofs_nx;
					hseen_q    <= hseen_nx;
					kcnt_q     <= kcnt_nx;
					cdown_q    <= cdown_nx;
					lkh_q      <= lkh_nx;
					ngt_q      <= ngt_nx;
					res_keep_q <= keep_w;
					res_ofs_q  <= OFS_W'(pos_w);
					if (grid_go) begin
						state_q <= ST_GRID;
					end else begin
						state_q <= ST_SEND;
					end
				end
				ST_GRID: begin
					if (grid_done) begin
						ngt_q   <= grid_next;
						state_q <= ST_SEND;
					end
				end
				ST_SEND: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_keep_q  <= res_keep_q;
						m_ofs_q   <= res_ofs_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_done_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		grid_done |-> (state_q == ST_GRID))
		else $error("grid unit finished outside the grid wait");

	a_grid_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GRID) |-> ((mode_q == MODE_TIME) && (tstep_q != '0)))
		else $error("grid wait without a time step in force");

	a_grid_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		grid_done |-> (grid_next > ts_q || grid_next == '1))
		else $error("next grid time not past the kept sample");

	a_offset_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL && !first_q) |=> (sofs_q >= $past(sofs_q)))
		else $error("sample position went back inside a window");
`endif

endmodule

`default_nettype wire

// ----- sim/tpd_tb_pkg.sv -----
// Register indexes, keep modes and the decision record shared by the decimator testbench.
`timescale 1ns / 1ps

package tpd_tb_pkg;

	import tpd_pkg::*;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE              = 3'd0,
		REG_TIME_STEP         = 3'd1,
		REG_HEADING_THRESHOLD = 3'd2,
		REG_POINT_STEP        = 3'd3,
		REG_MAX_POINTS        = 3'd4,
		REG_SPARE             = 3'd7
	} reg_index_e;

	typedef enum logic [MODE_W-1:0] {
		MODE_EVERY   = 2'd0,
		MODE_TIME    = 2'd1,
		MODE_HEADING = 2'd2,
		MODE_POINT   = 2'd3
	} decim_mode_e;

	typedef struct packed {
		logic             keep;
		logic [OFS_W-1:0] point_offset;
	} decision_t;

	localparam logic [TS_W-1:0]    TS_MAX   = '1;
	localparam logic [TSTEP_W-1:0] STEP_MAX = '1;
	localparam logic [MAXP_W-1:0]  MAXP_MAX = '1;

endpackage

// ----- sim/tpd_checker.sv -----
// Decimator checker: tracks register writes, predicts each keep decision and compares results.
`timescale 1ns / 1ps

module tpd_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	// timestamp_seconds [39:0], heading [55:40]
	input  logic [tpd_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// heading_valid [0], first_in_window [1]
	input  logic [tpd_pkg::S_TUSER_W-1:0]  s_axis_tuser,
	input  logic                           s_axis_tlast,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// point_offset [19:0], zeros above
	input  logic [tpd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	// keep [0]
	input  logic [0:0]                     m_axis_tuser,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [tpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tpd_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             errors,
	output int                             outstanding,
	output int                             checked,
	output int                             kept_seen
);

	import tpd_pkg::*;
	import tpd_tb_pkg::*;

	decim_mode_e             cur_mode;
	logic [TSTEP_W-1:0]      grid_step;
	logic [THR_W-1:0]        hdg_thr;
	logic [PSTEP_W-1:0]      pt_step;
	logic [MAXP_W-1:0]       pt_max;

	logic [TS_W-1:0]         grid_time;
	logic [HDG_W-1:0]        kept_heading;
	logic [INDEX_WIDTH-1:0]  next_offset;
	logic [MAXP_W-1:0]       pts_kept;
	logic [PSTEP_W-1:0]      skip_left;
	logic                    heading_held;

	decision_t               pending_decisions[$];
	decision_t               want;
	int                      err_total = 0;
	int                      checked_total = 0;
	int                      kept_total = 0;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		err_total++;
	endtask

	function automatic logic [TS_W-1:0] next_grid(input logic [TS_W-1:0] t,
		input logic [TSTEP_W-1:0] step);
		longint unsigned tt, st, sod, nxt;
		tt = t;
		st = step;
		if (st == 0) begin
			return t;
		end
		sod = tt % DAY_SECS;
		nxt = tt - sod + (sod / st + 1) * st;
		if (nxt > TS_MAX) begin
			return TS_MAX;
		end
		return TS_W'(nxt);
	endfunction

	function automatic logic [HDG_W-1:0] turn_delta(input logic [HDG_W-1:0] a,
		input logic [HDG_W-1:0] b);
		logic [HDG_W-1:0] d;
		d = (a > b) ? a - b : b - a;
		return (d > HALF_TURN) ? FULL_TURN - d : d;
	endfunction

	function automatic decision_t decide_sample(input logic [TS_W-1:0] t,
		input logic [HDG_W-1:0] hdg_raw, input logic hv, input logic first, input logic last);
		decision_t d;
		logic [HDG_W-1:0] hdg;
		hdg = hdg_raw % FULL_TURN;
		d.keep = 1'b0;
		if (first) begin
			next_offset = '0;
			heading_held = 1'b0;
			pts_kept = '0;
			skip_left = '0;
		end
		d.point_offset = OFS_W'(next_offset);
		if (next_offset != '1) begin
			next_offset++;
		end
		case (cur_mode)
			MODE_EVERY: begin
				d.keep = 1'b1;
			end
			MODE_TIME: begin
				d.keep = first || last || grid_step == '0 || t >= grid_time;
				if (d.keep) begin
					grid_time = next_grid(t, grid_step);
				end
			end
			MODE_HEADING: begin
				if (hv) begin
					d.keep = !heading_held || last || turn_delta(hdg, kept_heading) >= hdg_thr;
					if (d.keep) begin
						kept_heading = hdg;
						heading_held = 1'b1;
					end
				end
			end
			default: begin
				if (skip_left == '0) begin
					if (pts_kept < pt_max) begin
						d.keep = 1'b1;
						pts_kept++;
					end
					skip_left = (pt_step == '0) ? '0 : pt_step - 1'b1;
				end else begin
					skip_left--;
				end
			end
		endcase
		return d;
	endfunction

	function automatic void apply_register(input reg_index_e idx,
		input logic [CFG_DATA_W-1:0] v);
		case (idx)
			REG_MODE:              cur_mode = decim_mode_e'(v[MODE_W-1:0]);
			REG_TIME_STEP:         grid_step = v[TSTEP_W-1:0];
			REG_HEADING_THRESHOLD: hdg_thr = v[THR_W-1:0];
			REG_POINT_STEP:        pt_step = v[PSTEP_W-1:0];
			REG_MAX_POINTS:        pt_max = v[MAXP_W-1:0];
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode = MODE_EVERY;
			grid_step = '0;
			hdg_thr = '0;
			pt_step = PSTEP_W'(1);
			pt_max = MAXP_MAX;
			grid_time = '0;
			kept_heading = '0;
			next_offset = '0;
			pts_kept = '0;
			skip_left = '0;
			heading_held = 1'b0;
			pending_decisions.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				apply_register(reg_index_e'(cfg_index), cfg_data);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_decisions.size() == 0) begin
					report_mismatch($sformatf("unexpected result, offset %0d keep %0b",
						m_axis_tdata[OFS_W-1:0], m_axis_tuser[0]));
				end else begin
					want = pending_decisions.pop_front();
					checked_total++;
					if (want.keep) begin
						kept_total++;
					end
					if (m_axis_tuser[0] !== want.keep) begin
						report_mismatch($sformatf("offset %0d: keep %b, expected %b",
							want.point_offset, m_axis_tuser[0], want.keep));
					end
					if (m_axis_tdata[OFS_W-1:0] !== want.point_offset) begin
						report_mismatch($sformatf("point_offset %0d, expected %0d",
							m_axis_tdata[OFS_W-1:0], want.point_offset));
					end
					if (m_axis_tdata[M_TDATA_W-1:OFS_W] !== '0) begin
						report_mismatch($sformatf("tdata padding %b is not zero",
							m_axis_tdata[M_TDATA_W-1:OFS_W]));
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				pending_decisions.insert(pending_decisions.size(),
					decide_sample(s_axis_tdata[TS_W-1:0], s_axis_tdata[TS_W +: HDG_W],
					s_axis_tuser[0], s_axis_tuser[1], s_axis_tlast));
			end
			outstanding <= pending_decisions.size();
		end
		errors <= err_total;
		checked <= checked_total;
		kept_seen <= kept_total;
	end

endmodule

// ----- sim/tb_top.sv -----
// Decimator testbench top: clock, reset, register settings, sample stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

	import tpd_pkg::*;
	import tpd_tb_pkg::*;

	localparam int      HOLD_CYCLES   = 400;
	localparam int      SETTLE_CYCLES = 40;
	localparam longint  TIMEOUT_NS    = 10_000_000;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [S_TDATA_W-1:0]   s_axis_tdata;
	logic [S_TUSER_W-1:0]   s_axis_tuser;
	logic                   s_axis_tlast;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [M_TDATA_W-1:0]   m_axis_tdata;
	logic [0:0]             m_axis_tuser;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int   errors;
	int   outstanding;
	int   checked;
	int   kept_seen;
	int   idle_pct;
	int   stall_pct;
	bit   hold_request;
	int   samples_sent = 0;
	int   settings_loaded = 0;

	track_point_decimator_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	tpd_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.outstanding   (outstanding),
		.checked       (checked),
		.kept_seen     (kept_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#TIMEOUT_NS;
		$display("Timed out with %0d results still expected", outstanding);
		$display("track_point_decimator_core test failed");
		$finish;
	end

	// output side: random stalls, plus one long hold on request
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic offer_sample(input logic [TS_W-1:0] ts, input logic [HDG_W-1:0] hdg,
		input logic hv, input logic first, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= S_TDATA_W'({hdg, ts});
		s_axis_tuser <= {first, hv};
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		samples_sent++;
	endtask

	task automatic write_register(input reg_index_e idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// drain every pending result, then reprogram all registers
	task automatic load_settings(input decim_mode_e m, input logic [CFG_DATA_W-1:0] step,
		input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] pstep,
		input logic [CFG_DATA_W-1:0] maxp);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_register(REG_MODE, CFG_DATA_W'(m));
		write_register(REG_TIME_STEP, step);
		write_register(REG_HEADING_THRESHOLD, thr);
		write_register(REG_POINT_STEP, pstep);
		write_register(REG_MAX_POINTS, maxp);
		cfg_valid <= 1'b0;
		settings_loaded++;
	endtask

	task automatic run_track(input int len, input logic [TS_W-1:0] start, input int max_gap);
		logic [TS_W-1:0]  ts;
		logic [HDG_W-1:0] hdg;
		int               course;
		ts = start;
		course = $urandom_range(35999);
		for (int i = 0; i < len; i++) begin
			hdg = ($urandom_range(15) == 0) ? HDG_W'($urandom) : HDG_W'(course);
			offer_sample(ts, hdg, $urandom_range(9) != 0, i == 0, i == len - 1);
			ts = ts + TS_W'($urandom_range(max_gap));
			course = (course + 32000 + int'($urandom_range(8000))) % 36000;
		end
	endtask

	task automatic offer_noise(input int count);
		repeat (count) begin
			offer_sample(TS_W'({$urandom, $urandom}), HDG_W'($urandom), 1'($urandom_range(1)),
				1'($urandom_range(1)), 1'($urandom_range(1)));
		end
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_step();
		case ($urandom_range(7))
			0: return '0;
			1: return CFG_DATA_W'(1);
			2: return CFG_DATA_W'(60);
			3: return CFG_DATA_W'(86400);
			4: return CFG_DATA_W'(STEP_MAX);
			5: return CFG_DATA_W'($urandom_range(STEP_MAX));
			default: return CFG_DATA_W'($urandom_range(3600, 1));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_threshold();
		case ($urandom_range(6))
			0: return '0;
			1: return CFG_DATA_W'(18000);
			2: return CFG_DATA_W'(36000);
			3: return CFG_DATA_W'($urandom_range(65535));
			default: return CFG_DATA_W'($urandom_range(6000));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_point_step();
		case ($urandom_range(6))
			0: return '0;
			1: return CFG_DATA_W'(1);
			2: return CFG_DATA_W'(65535);
			3: return CFG_DATA_W'($urandom_range(65535));
			default: return CFG_DATA_W'($urandom_range(8, 2));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_max_points();
		case ($urandom_range(5))
			0: return '0;
			1: return CFG_DATA_W'(MAXP_MAX);
			2: return CFG_DATA_W'($urandom_range(MAXP_MAX));
			default: return CFG_DATA_W'($urandom_range(12, 1));
		endcase
	endfunction

	function automatic logic [TS_W-1:0] pick_start();
		case ($urandom_range(3))
			0: return TS_W'(64'd1700000000 + 64'($urandom_range(100000000)));
			1: return TS_W'(64'($urandom_range(12000000)) * 64'd86400 + 64'd86400
				- 64'($urandom_range(300)));
			2: return TS_MAX - TS_W'($urandom_range(200000));
			default: return TS_W'({$urandom, $urandom});
		endcase
	endfunction

	function automatic int pick_gap();
		case ($urandom_range(5))
			0: return 0;
			1: return 1;
			2: return 30;
			3: return 600;
			4: return 20000;
			default: return 90000;
		endcase
	endfunction

	initial begin
		int sent_goal;
		int room;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		s_axis_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_request = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unused index must leave the registers alone
		write_register(REG_SPARE, '1);
		cfg_valid <= 1'b0;

		// reset settings, before any window is opened
		offer_sample('0, '0, 1'b0, 1'b0, 1'b0);
		offer_sample(TS_MAX, HDG_W'(35999), 1'b1, 1'b0, 1'b1);
		offer_sample(TS_W'(1700000000), '1, 1'b1, 1'b1, 1'b0);
		offer_sample(TS_W'(1700000001), '0, 1'b1, 1'b0, 1'b1);

		// zero time step keeps every point
		load_settings(MODE_TIME, '0, '0, CFG_DATA_W'(1), CFG_DATA_W'(MAXP_MAX));
		offer_sample(TS_W'(1000), '0, 1'b0, 1'b1, 1'b0);
		offer_sample(TS_W'(1000), '0, 1'b0, 1'b0, 1'b0);

		// grid past the top of the timestamp range saturates
		load_settings(MODE_TIME, CFG_DATA_W'(86400), '0, CFG_DATA_W'(1), CFG_DATA_W'(MAXP_MAX));
		offer_sample(TS_MAX - TS_W'(5), '0, 1'b1, 1'b1, 1'b0);
		offer_sample(TS_MAX - TS_W'(1), '0, 1'b1, 1'b0, 1'b0);
		offer_sample(TS_MAX, '0, 1'b1, 1'b0, 1'b0);

		// day rollover
		offer_sample(TS_W'(64'd86400 * 20000 + 86399), '0, 1'b1, 1'b1, 1'b0);
		offer_sample(TS_W'(64'd86400 * 20001), '0, 1'b1, 1'b0, 1'b0);
		offer_sample(TS_W'(64'd86400 * 20001 + 1), '0, 1'b1, 1'b0, 1'b0);
		offer_sample(TS_W'(64'd86400 * 20001 + 2), '0, 1'b1, 1'b0, 1'b1);

		// step longer than a day
		load_settings(MODE_TIME, CFG_DATA_W'(STEP_MAX), '0, CFG_DATA_W'(1),
			CFG_DATA_W'(MAXP_MAX));
		offer_sample(TS_W'(64'd86400 * 5 + 86000), '0, 1'b0, 1'b1, 1'b0);
		offer_sample(TS_W'(64'd86400 * 5 + 87000), '0, 1'b0, 1'b0, 1'b0);
		offer_sample(TS_W'(64'd86400 * 5 + 131071), '0, 1'b0, 1'b0, 1'b0);

		// heading: invalid start, wrapped raw heading, unreachable threshold, last flag
		load_settings(MODE_HEADING, '0, CFG_DATA_W'(36000), CFG_DATA_W'(1),
			CFG_DATA_W'(MAXP_MAX));
		offer_sample(TS_W'(10), HDG_W'(100), 1'b0, 1'b1, 1'b0);
		offer_sample(TS_W'(11), '1, 1'b1, 1'b0, 1'b0);
		offer_sample(TS_W'(12), '0, 1'b1, 1'b0, 1'b0);
		offer_sample(TS_W'(13), HDG_W'(9000), 1'b0, 1'b0, 1'b1);
		offer_sample(TS_W'(14), HDG_W'(18000), 1'b1, 1'b0, 1'b1);

		// point step zero with no points allowed, then every third up to two
		load_settings(MODE_POINT, '0, '0, '0, '0);
		offer_sample(TS_W'(20), '0, 1'b1, 1'b1, 1'b0);
		offer_sample(TS_W'(21), '0, 1'b1, 1'b0, 1'b0);
		load_settings(MODE_POINT, '0, '0, CFG_DATA_W'(3), CFG_DATA_W'(2));
		run_track(8, TS_W'(30), 1);

		for (int phase = 0; phase < 16; phase++) begin
			case (phase % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 67; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 67; end
				default: begin idle_pct = 35; stall_pct = 35; end
			endcase
			load_settings(decim_mode_e'((phase + phase / 4) % 4), pick_step(), pick_threshold(),
				pick_point_step(), pick_max_points());
			sent_goal = samples_sent + 80;
			while (samples_sent < sent_goal) begin
				room = sent_goal - samples_sent;
				if ($urandom_range(9) == 0) begin
					offer_noise($urandom_range(4, 1));
				end else begin
					run_track($urandom_range((room < 24) ? room : 24, 1), pick_start(),
						pick_gap());
				end
			end
			// hold the output long enough for the input to back up
			if (phase == 8) begin
				hold_request = 1'b1;
				run_track(40, pick_start(), 30);
			end
		end

		s_axis_tvalid <= 1'b0;
		stall_pct = 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d samples under %0d register settings in all four modes,",
			samples_sent, settings_loaded);
		$display("paced back-to-back to two-thirds idle, %0d-cycle output hold, %0d of %0d kept.",
			HOLD_CYCLES, kept_seen, checked);
		if (errors == 0) begin
			$display("track_point_decimator_core test passed");
		end else begin
			$display("track_point_decimator_core test failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/tpd_pkg.sv
rtl/tpd_grid_unit.sv
rtl/track_point_decimator_core.sv
sim/tpd_tb_pkg.sv
sim/tpd_checker.sv
sim/tb_top.sv
